[hdl/spt_pkg.sv]
// ---------------------------------------------------------------------------
// spt_pkg
// Shared types, widths and codes for the sorted process table.
// ---------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

  localparam int DEPTH_DEFAULT    = 16;
  localparam int ID_WIDTH_DEFAULT = 16;

  localparam int CMD_W    = 2;
  localparam int PID_W    = 16;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP_MISSING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BOUNDS      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } op_ctl_t;

  // registered compare results of one cell
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

`default_nettype wire

[hdl/spt_req_if.sv]
// ---------------------------------------------------------------------------
// spt_req_if
// Request channel: command word with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface spt_req_if;
  logic                       valid;
  logic                       ready;
  logic [spt_pkg::CMD_W-1:0]  command;
  logic [spt_pkg::PID_W-1:0]  pid_value;
  logic [spt_pkg::POS_W-1:0]  position;

  modport source (output valid, output command, output pid_value, output position,
                  input ready);
  modport sink   (input valid, input command, input pid_value, input position,
                  output ready);
endinterface

`default_nettype wire

[hdl/spt_rsp_if.sv]
// ---------------------------------------------------------------------------
// spt_rsp_if
// Response channel: status word with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface spt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [spt_pkg::STATUS_W-1:0]  status;
  logic [spt_pkg::PID_W-1:0]     found_pid;
  logic [spt_pkg::PID_W-1:0]     parent_pid;

  modport source (output valid, output status, output found_pid, output parent_pid,
                  input ready);
  modport sink   (input valid, input status, input found_pid, input parent_pid,
                  output ready);
endinterface

`default_nettype wire

[hdl/spt_cell.sv]
// ---------------------------------------------------------------------------
// spt_cell
// One table slot: holds an ID and its parent, compares against the broadcast
// key and shifts to or from its neighbors on insert and remove.
// ---------------------------------------------------------------------------
`default_nettype none

module spt_cell #(
  parameter int ID_WIDTH = spt_pkg::ID_WIDTH_DEFAULT,
  parameter int IDX      = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire spt_pkg::op_ctl_t           ctl,
  input  wire logic [ID_WIDTH-1:0]        key,
  input  wire logic [spt_pkg::POS_W-1:0]  pos,
  input  wire logic                       left_valid,
  input  wire logic [ID_WIDTH-1:0]        left_id,
  input  wire logic [ID_WIDTH-1:0]        left_par,
  input  wire logic                       left_lt,
  input  wire logic                       right_valid,
  input  wire logic [ID_WIDTH-1:0]        right_id,
  input  wire logic [ID_WIDTH-1:0]        right_par,
  output logic                            valid,
  output logic [ID_WIDTH-1:0]             id,
  output logic [ID_WIDTH-1:0]             par,
  output spt_pkg::cell_flags_t            flags,
  output logic [ID_WIDTH-1:0]             rd_id,
  output logic [ID_WIDTH-1:0]             rd_par
);

  localparam logic [spt_pkg::POS_W-1:0] MY_POS = spt_pkg::POS_W'(IDX);

  logic sel;

  assign sel = valid && (pos == MY_POS);

  // compare phase: flags and the masked read word
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      flags.lt <= valid && (id < key);
      flags.eq <= valid && (id == key);
      rd_id    <= sel ? id  : '0;
      rd_par   <= sel ? par : '0;
    end
  end

  // apply phase: shift right on insert, shift left on remove
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= (IDX == 0);
      id    <= (IDX == 0) ? ID_WIDTH'(1) : '0;
      par   <= '0;
    end else if (ctl.ins && !flags.lt) begin
      if (left_lt) begin
        valid <= 1'b1;
        id    <= key;
        par   <= left_id;
      end else begin
        valid <= left_valid;
        id    <= left_id;
        par   <= left_par;
      end
    end else if (ctl.rem && valid && !flags.lt) begin
      valid <= right_valid;
      id    <= right_id;
      par   <= right_par;
    end
  end

endmodule

`default_nettype wire

[hdl/sorted_process_table_unit.sv]
// ---------------------------------------------------------------------------
// sorted_process_table_unit
// Sorted table of process IDs built as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Each request passes through the states S_IDLE, in which the word is
// accepted and latched, S_CMP, in which every cell compares its ID with the
// key in parallel, and S_APPLY, in which the cells shift by one slot (insert
// or remove) or the addressed cell is read (get). The response register is
// loaded at the edge that ends S_APPLY. A new word is accepted only once the
// apply state has written the response, so each word is through the cell
// chain before the next is taken, as set by the compare-then-shift sequence.
// A response that is still held stalls the apply cycle, and the input stays
// closed until it moves. The response register lets the next word in while a
// result waits. After reset the table holds ID 1 with parent 0 in slot zero;
// that entry never moves.
`default_nettype none

module sorted_process_table_unit #(
  parameter int TABLE_DEPTH = spt_pkg::DEPTH_DEFAULT,
  parameter int ID_WIDTH    = spt_pkg::ID_WIDTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  spt_req_if.sink     req,
  spt_rsp_if.source   rsp
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > spt_pkg::POS_W) ? CNT_W : spt_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state, state_next;

  logic [spt_pkg::CMD_W-1:0]  cmd_q;
  logic [ID_WIDTH-1:0]        key_q;
  logic [spt_pkg::POS_W-1:0]  pos_q;
  logic [CNT_W-1:0]           count;

  logic                          rsp_valid;
  logic [spt_pkg::STATUS_W-1:0]  rsp_status;
  logic [spt_pkg::PID_W-1:0]     rsp_found;
  logic [spt_pkg::PID_W-1:0]     rsp_parent;

  spt_pkg::op_ctl_t     ctl;
  spt_pkg::cell_flags_t flags [TABLE_DEPTH];
  logic                 cell_valid [TABLE_DEPTH];
  logic [ID_WIDTH-1:0]  cell_id    [TABLE_DEPTH];
  logic [ID_WIDTH-1:0]  cell_par   [TABLE_DEPTH];
  logic [ID_WIDTH-1:0]  rd_id      [TABLE_DEPTH];
  logic [ID_WIDTH-1:0]  rd_par     [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_vec;

  logic                          accept;
  logic                          apply_go;
  logic                          found;
  logic                          key_bad;
  logic                          get_ok;
  logic [ID_WIDTH-1:0]           rd_id_all;
  logic [ID_WIDTH-1:0]           rd_par_all;
  logic [spt_pkg::STATUS_W-1:0]  status_next;
  logic                          do_ins;
  logic                          do_rem;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign apply_go  = (state == S_APPLY) && (!rsp_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (apply_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.command;
      key_q <= ID_WIDTH'(32'(req.pid_value));
      pos_q <= req.position;
    end
  end

  // ---- cell chain ----
  assign ctl.cmp = (state == S_CMP);
  assign ctl.ins = apply_go && do_ins;
  assign ctl.rem = apply_go && do_rem;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                left_valid, left_lt, right_valid;
    logic [ID_WIDTH-1:0] left_id, left_par, right_id, right_par;

    if (i == 0) begin : g_head
      assign left_valid = 1'b0;
      assign left_lt    = 1'b0;
      assign left_id    = '0;
      assign left_par   = '0;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
      assign left_lt    = flags[i-1].lt;
      assign left_id    = cell_id[i-1];
      assign left_par   = cell_par[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_id    = '0;
      assign right_par   = '0;
    end else begin : g_body
      assign right_valid = cell_valid[i+1];
      assign right_id    = cell_id[i+1];
      assign right_par   = cell_par[i+1];
    end

    spt_cell #(
      .ID_WIDTH (ID_WIDTH),
      .IDX      (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key         (key_q),
      .pos         (pos_q),
      .left_valid  (left_valid),
      .left_id     (left_id),
      .left_par    (left_par),
      .left_lt     (left_lt),
      .right_valid (right_valid),
      .right_id    (right_id),
      .right_par   (right_par),
      .valid       (cell_valid[i]),
      .id          (cell_id[i]),
      .par         (cell_par[i]),
      .flags       (flags[i]),
      .rd_id       (rd_id[i]),
      .rd_par      (rd_par[i])
    );

    assign valid_vec[i] = cell_valid[i];
  end

  // only the addressed cell has a nonzero read word
  always_comb begin
    found      = 1'b0;
    rd_id_all  = '0;
    rd_par_all = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      found      = found | flags[k].eq;
      rd_id_all  = rd_id_all | rd_id[k];
      rd_par_all = rd_par_all | rd_par[k];
    end
  end

  assign key_bad = (key_q <= ID_WIDTH'(1));
  assign get_ok  = (CMP_W'(pos_q) < CMP_W'(count));

  always_comb begin
    status_next = spt_pkg::ST_INVALID;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    unique case (cmd_q)
      spt_pkg::CMD_INSERT: begin
        if (key_bad) begin
          status_next = spt_pkg::ST_INVALID;
        end else if (found) begin
          status_next = spt_pkg::ST_DUP_MISSING;
        end else if (count == CNT_W'(TABLE_DEPTH)) begin
          status_next = spt_pkg::ST_FULL;
        end else begin
          status_next = spt_pkg::ST_OK;
          do_ins      = 1'b1;
        end
      end
      spt_pkg::CMD_REMOVE: begin
        if (key_bad) begin
          status_next = spt_pkg::ST_INVALID;
        end else if (!found) begin
          status_next = spt_pkg::ST_DUP_MISSING;
        end else begin
          status_next = spt_pkg::ST_OK;
          do_rem      = 1'b1;
        end
      end
      spt_pkg::CMD_GET: begin
        status_next = get_ok ? spt_pkg::ST_OK : spt_pkg::ST_BOUNDS;
      end
      default: status_next = spt_pkg::ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
    end else if (ctl.ins) begin
      count <= count + CNT_W'(1);
    end else if (ctl.rem) begin
      count <= count - CNT_W'(1);
    end
  end

  // ---- response register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp_status <= status_next;
      if (cmd_q == spt_pkg::CMD_GET && get_ok) begin
        rsp_found  <= spt_pkg::PID_W'(32'(rd_id_all));
        rsp_parent <= spt_pkg::PID_W'(32'(rd_par_all));
      end else begin
        rsp_found  <= '0;
        rsp_parent <= '0;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.found_pid  = rsp_found;
  assign rsp.parent_pid = rsp_parent;

  // ---- assertions ----
  a_root_entry: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] && (cell_id[0] == ID_WIDTH'(1)))
    else $error("slot zero lost the root entry");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid_vec)))
    else $error("entry count disagrees with occupied cells");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied cells are not contiguous from slot zero");

  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ins && ctl.rem))
    else $error("insert and remove shift in the same cycle");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_APPLY))
    else $error("response appeared without an apply cycle");

endmodule

`default_nettype wire

[tb/spt_table_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// spt_table_checker
// Watches the request and response channels of the sorted process table.
// Every accepted request word is applied to a local copy of the table. The
// reply that this gives is queued, and each accepted response word is
// compared with the oldest queued reply, field by field.
// ---------------------------------------------------------------------------

module spt_table_checker
  import spt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  spt_req_if   req,
  spt_rsp_if   rsp,
  output int   mismatches,
  output int   replies_due
);

  localparam int DEPTH = DEPTH_DEFAULT;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    found_pid;
    logic [PID_W-1:0]    parent_pid;
  } reply_t;

  // local copy of the table, slot zero is the root entry
  logic [PID_W-1:0] ids     [DEPTH];
  logic [PID_W-1:0] parents [DEPTH];
  int               used;

  reply_t replies [$];

  function automatic reply_t apply_table_op(input logic [CMD_W-1:0] cmd,
                                            input logic [PID_W-1:0] pid,
                                            input logic [POS_W-1:0] pos);
    reply_t r;
    int     at;
    int     k;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (pid <= 1) begin
          r.status = ST_INVALID;
        end else begin
          // at ends on the last entry below the new ID, which becomes its parent
          at = 0;
          while (at + 1 < used && ids[at+1] < pid) at++;
          if (at + 1 < used && ids[at+1] == pid) begin
            r.status = ST_DUP_MISSING;
          end else if (used >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (k = used; k > at + 1; k--) begin
              ids[k]     = ids[k-1];
              parents[k] = parents[k-1];
            end
            ids[at+1]     = pid;
            parents[at+1] = ids[at];
            used++;
            r.status = ST_OK;
          end
        end
      end
      CMD_REMOVE: begin
        if (pid <= 1) begin
          r.status = ST_INVALID;
        end else begin
          at = 0;
          while (at < used && ids[at] != pid) at++;
          if (at >= used) begin
            r.status = ST_DUP_MISSING;
          end else begin
            for (k = at; k + 1 < used; k++) begin
              ids[k]     = ids[k+1];
              parents[k] = parents[k+1];
            end
            used--;
            ids[used]     = '0;
            parents[used] = '0;
            r.status = ST_OK;
          end
        end
      end
      CMD_GET: begin
        if (pos < used) begin
          r.status     = ST_OK;
          r.found_pid  = ids[pos];
          r.parent_pid = parents[pos];
        end else begin
          r.status = ST_BOUNDS;
        end
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t exp_word;
    reply_t got_word;
    if (rst) begin
      foreach (ids[i]) begin
        ids[i]     = '0;
        parents[i] = '0;
      end
      ids[0] = 1;
      used   = 1;
      replies.delete();
      mismatches  <= 0;
      replies_due <= 0;
    end else begin
      // response side first: a word accepted now never answers the request
      // accepted on the same edge
      if (rsp.valid && rsp.ready) begin
        got_word = '{rsp.status, rsp.found_pid, rsp.parent_pid};
        if (replies.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected response word status=%0d found=%0d parent=%0d",
                     $realtime, got_word.status, got_word.found_pid,
                     got_word.parent_pid);
          mismatches <= mismatches + 1;
        end else begin
          exp_word = replies.pop_front();
          if (got_word !== exp_word) begin
            if (mismatches < 10)
              $display("%0t: response mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       $realtime, exp_word.status, exp_word.found_pid,
                       exp_word.parent_pid, got_word.status, got_word.found_pid,
                       got_word.parent_pid);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (req.valid && req.ready)
        replies.push_back(apply_table_op(req.command, req.pid_value, req.position));
      replies_due <= replies.size();
    end
  end

endmodule

[tb/tb_sorted_process_table_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sorted_process_table_unit
// Drives insert, remove, get and spare words into the sorted process table
// with random idling on both channels, one long response hold-off and a drain
// pause. Checking is done by spt_table_checker; this module gives the verdict.
// ---------------------------------------------------------------------------

module tb_sorted_process_table_unit;
  import spt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   replies_due;
  int   idle_pct;
  logic hold_req;
  logic hold_taken;
  int   stall_left;
  int   quiet_cycles;

  spt_req_if req ();
  spt_rsp_if rsp ();

  sorted_process_table_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  spt_table_checker table_check (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .mismatches(mismatches),
    .replies_due(replies_due)
  );

  always #1 clk = ~clk;

  // response side: random stall bursts plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready  <= 1'b0;
      stall_left <= 0;
      hold_taken <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (hold_req && !hold_taken) begin
      rsp.ready  <= 1'b0;
      stall_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      rsp.ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
                           input logic [POS_W-1:0] pos);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 9);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.command   <= cmd;
    req.pid_value <= pid;
    req.position  <= pos;
    do @(posedge clk); while (!req.ready);
  endtask

  // mostly small IDs so that duplicates, hits on remove and a full table are common
  task automatic send_random(input int ins_w, input int rem_w);
    logic [CMD_W-1:0] cmd;
    logic [PID_W-1:0] pid;
    logic [POS_W-1:0] pos;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < ins_w)
      cmd = CMD_INSERT;
    else if (pick < ins_w + rem_w)
      cmd = CMD_REMOVE;
    else if (pick < 97)
      cmd = CMD_GET;
    else
      cmd = CMD_SPARE;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      pid = PID_W'($urandom());
    else if (pick == 1)
      pid = PID_W'($urandom_range(0, 1));
    else
      pid = PID_W'($urandom_range(2, 40));
    if ($urandom_range(0, 9) == 0)
      pos = POS_W'($urandom());
    else
      pos = POS_W'($urandom_range(0, 17));
    send_word(cmd, pid, pos);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (replies_due != 0);
  endtask

  initial begin
    rst           = 1'b1;
    idle_pct      = 30;
    hold_req      = 1'b0;
    req.valid     = 1'b0;
    req.command   = CMD_INSERT;
    req.pid_value = '0;
    req.position  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: root entry, bounds, invalid IDs, duplicates, parents, spare command
    send_word(CMD_GET, 16'd0, 8'd0);
    send_word(CMD_GET, 16'd0, 8'd1);
    send_word(CMD_GET, 16'hFFFF, 8'd255);
    send_word(CMD_INSERT, 16'd0, 8'd0);
    send_word(CMD_INSERT, 16'd1, 8'd255);
    send_word(CMD_REMOVE, 16'd1, 8'd0);
    send_word(CMD_REMOVE, 16'd0, 8'd0);
    send_word(CMD_INSERT, 16'hFFFF, 8'd0);
    send_word(CMD_INSERT, 16'd2, 8'd0);
    send_word(CMD_INSERT, 16'hFFFF, 8'd0);
    send_word(CMD_REMOVE, 16'd3, 8'd0);
    send_word(CMD_GET, 16'd0, 8'd1);
    send_word(CMD_GET, 16'd0, 8'd2);
    send_word(CMD_INSERT, 16'd100, 8'd0);
    send_word(CMD_GET, 16'd0, 8'd2);
    send_word(CMD_SPARE, 16'hFFFF, 8'd255);
    send_word(CMD_REMOVE, 16'd2, 8'd0);
    send_word(CMD_GET, 16'd0, 8'd1);
    send_word(CMD_GET, 16'd0, 8'd3);
    send_word(CMD_REMOVE, 16'hFFFF, 8'd0);
    send_word(CMD_GET, 16'd0, 8'd1);

    // insert-heavy: drives the table full and into duplicates
    repeat (150) send_random(70, 10);

    // long response hold-off while words keep coming back to back
    idle_pct <= 0;
    hold_req <= 1'b1;
    repeat (24) send_random(40, 30);
    req.valid <= 1'b0;
    wait_drained();
    idle_pct <= 35;

    repeat (150) send_random(10, 65);
    repeat (300) send_random(45, 30);
    idle_pct <= 8;
    repeat (200) send_random(50, 35);

    // closing stretch with no idling on either side
    idle_pct <= 0;
    repeat (150) send_random(45, 30);

    req.valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
hdl/spt_pkg.sv
hdl/spt_req_if.sv
hdl/spt_rsp_if.sv
hdl/spt_cell.sv
hdl/sorted_process_table_unit.sv
tb/spt_table_checker.sv
tb/tb_sorted_process_table_unit.sv
